// File: rtl/window_cooccurrence_counter_macros.svh
// Assertion macros used by the co-occurrence counter checker.
`ifndef WINDOW_COOCCURRENCE_COUNTER_MACROS_SVH
`define WINDOW_COOCCURRENCE_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define WCC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("window_cooccurrence_counter: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define WCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("window_cooccurrence_counter: next-cycle check failed");

`endif

// File: rtl/wcc_pkg.sv
// Shared constants and types of the window co-occurrence counter.
package wcc_pkg;

  // Default sizes of the block
  localparam int WINDOW_DEF     = 30;
  localparam int BUCKETS_DEF    = 512;
  localparam int COUNT_BITS_DEF = 32;

  // Fixed port field widths
  localparam int KIND_W      = 2;
  localparam int CHAR_W      = 16;
  localparam int IDX_W       = 9;
  localparam int OUT_COUNT_W = 32;

  // Input item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR  = 2'd0,
    KIND_START = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  // Status of the pair table toward the sequencer
  typedef struct packed {
    logic clearing;  // reset sweep still running
    logic busy;      // read-modify-write in flight
  } tbl_stat_t;

endpackage

// File: rtl/wcc_bucket_mod.sv
// Three-stage reduction of a character code modulo the bucket count.
module wcc_bucket_mod import wcc_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  localparam int BW = $clog2(BUCKETS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [CHAR_W-1:0] in_val,
  output logic              out_vld,
  output logic [BW-1:0]     out_bucket
);

  // floor(2^W / B): the quotient estimate is low by at most one
  localparam logic [CHAR_W-1:0] RECIP   = CHAR_W'((2 ** CHAR_W) / BUCKETS);
  localparam logic [CHAR_W-1:0] DIVISOR = CHAR_W'(BUCKETS);

  logic [2:0]          vld_r;
  logic [CHAR_W-1:0]   x1_r, x2_r;
  logic [2*CHAR_W-1:0] prod_nxt, prod_r;
  logic [2*CHAR_W-1:0] qb_full;
  logic [CHAR_W-1:0]   qb_r;
  logic [CHAR_W-1:0]   rem, rem_fix;
  logic [BW-1:0]       bucket_r;

  // stage 1: code times reciprocal
  assign prod_nxt = {{CHAR_W{1'b0}}, in_val} * {{CHAR_W{1'b0}}, RECIP};

  // stage 2: quotient estimate back times divisor
  assign qb_full = {{CHAR_W{1'b0}}, prod_r[2*CHAR_W-1:CHAR_W]} * {{CHAR_W{1'b0}}, DIVISOR};

  // stage 3: remainder with one correction step
  assign rem     = x2_r - qb_r;
  assign rem_fix = (rem >= DIVISOR) ? rem - DIVISOR : rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    x1_r     <= in_val;
    prod_r   <= prod_nxt;
    x2_r     <= x1_r;
    qb_r     <= qb_full[CHAR_W-1:0];
    bucket_r <= rem_fix[BW-1:0];
  end

  assign out_vld    = vld_r[2];
  assign out_bucket = bucket_r;

endmodule

// File: rtl/wcc_pair_table.sv
// Pair counter memory: reset sweep, saturating read-modify-write, read port.
module wcc_pair_table import wcc_pkg::*; #(
  parameter int BUCKETS    = BUCKETS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int BW = $clog2(BUCKETS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  bump_vld,
  input  logic [BW-1:0]         bump_row,
  input  logic [BW-1:0]         bump_col,
  input  logic                  rd_req,
  input  logic [BW-1:0]         rd_row,
  input  logic [BW-1:0]         rd_col,
  output logic [COUNT_BITS-1:0] rd_count,
  output tbl_stat_t             stat
);

  localparam int AW    = 2 * BW;
  localparam int DEPTH = 2 ** AW;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [COUNT_BITS-1:0] mem [DEPTH];

  logic                  clr_active_r, clr_active_nxt;
  logic [AW-1:0]         clr_addr_r, clr_addr_nxt;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [COUNT_BITS-1:0] rd_q_r;
  logic                  upd_vld_r;
  logic [AW-1:0]         upd_addr_r;
  logic                  fwd_vld_r;
  logic [AW-1:0]         fwd_addr_r;
  logic [COUNT_BITS-1:0] fwd_data_r;
  logic [COUNT_BITS-1:0] old_cnt, new_cnt;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  // one read port, shared by increments and read items
  assign rd_en   = bump_vld | rd_req;
  assign rd_addr = bump_vld ? {bump_row, bump_col} : {rd_row, rd_col};

  // the write of the previous cycle is not yet in the read data
  assign old_cnt = (fwd_vld_r && (fwd_addr_r == upd_addr_r)) ? fwd_data_r : rd_q_r;
  assign new_cnt = (old_cnt == CNT_MAX) ? old_cnt : old_cnt + COUNT_BITS'(1);

  // write port: sweep after reset, otherwise the increment
  assign wr_en   = clr_active_r | upd_vld_r;
  assign wr_addr = clr_active_r ? clr_addr_r : upd_addr_r;
  assign wr_data = clr_active_r ? '0 : new_cnt;

  // reset sweep over every entry
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == {AW{1'b1}}) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      upd_vld_r    <= 1'b0;
      fwd_vld_r    <= 1'b0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
      upd_vld_r    <= bump_vld;
      fwd_vld_r    <= upd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    upd_addr_r <= rd_addr;
    fwd_addr_r <= upd_addr_r;
    fwd_data_r <= new_cnt;
  end

  // counter memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_count = rd_q_r;
  assign stat     = '{clearing: clr_active_r, busy: upd_vld_r};

endmodule

// File: rtl/window_cooccurrence_counter.sv
// Window co-occurrence counter: sequencer, character ring and result register.
//
// Input channel (in_valid / in_stall): one item per transfer. kind 0 is a
// character, kind 1 starts a new text, kind 2 reads the counter at (row, col),
// kind 3 is ignored. Result channel (out_valid / out_stall): one count and
// saturation flag for each read, in order of the reads.
// The block works on one item at a time; in_stall is high while it does.
//   start of text, kind 3      : taken in the idle state, in_stall stays low
//   character while filling    : modulo pipeline, ring write
//   character with counting    : modulo pipeline, ring write, then one ring
//                                read and one counter update a cycle for each
//                                ring entry, plus the drain of the update pipe
//   read                       : modulo pipeline, table read, result register
// Counter updates stream through the shared table read port with
// one-deep write forwarding, so repeated buckets count correctly.
// After reset the table is swept to zero, one entry a cycle, over all
// 2^(2*clog2(BUCKETS)) entries (262144 at BUCKETS = 512); in_stall stays high.
// A result held by out_stall sits in the output register; the block keeps
// taking items and only a following read waits for that register to empty.
module window_cooccurrence_counter import wcc_pkg::*; #(
  parameter int WINDOW     = WINDOW_DEF,
  parameter int BUCKETS    = BUCKETS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [CHAR_W-1:0]      in_char_code,
  input  logic [IDX_W-1:0]       in_row,
  input  logic [IDX_W-1:0]       in_col,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OUT_COUNT_W-1:0] out_count,
  output logic                   out_saturated
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int PW    = $clog2(WINDOW);
  localparam int FW    = $clog2(WINDOW + 1);
  localparam int EXT_W = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_REDUCE = 6'b000100,
    ST_BUMP   = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   is_read_r, is_read_nxt;
  logic [PW-1:0]          ptr_r, ptr_nxt, ptr_adv;
  logic [FW-1:0]          fill_r, fill_nxt;
  logic [BW-1:0]          col_bkt_r, col_bkt_nxt;
  logic [PW-1:0]          bump_idx_r, bump_idx_nxt;
  logic                   ring_q_vld_r;
  logic [BW-1:0]          ring_q_r;
  logic [BW-1:0]          ring_mem [WINDOW];
  logic                   ring_wr_en, ring_rd_en;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_COUNT_W-1:0] out_count_r, out_count_nxt;
  logic                   out_sat_r, out_sat_nxt;

  logic                   in_accept;
  logic                   red_start;
  logic [CHAR_W-1:0]      red_a_in, red_b_in;
  logic                   red_a_vld, red_b_vld, red_done;
  logic [BW-1:0]          red_a_bkt, red_b_bkt;
  logic                   tbl_rd_req;
  logic [COUNT_BITS-1:0]  tbl_count;
  logic [EXT_W-1:0]       cnt_ext;
  tbl_stat_t              tbl_stat;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid & ~in_stall;

  // bucket reduction: code or row on one unit, col on the other
  assign red_start = in_accept & ((in_kind == KIND_CHAR) | (in_kind == KIND_READ));
  assign red_a_in  = (in_kind == KIND_READ) ? CHAR_W'(in_row) : in_char_code;
  assign red_b_in  = CHAR_W'(in_col);
  assign red_done  = red_a_vld & red_b_vld;

  wcc_bucket_mod #(.BUCKETS(BUCKETS)) u_mod_a (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (red_start),
    .in_val     (red_a_in),
    .out_vld    (red_a_vld),
    .out_bucket (red_a_bkt)
  );

  wcc_bucket_mod #(.BUCKETS(BUCKETS)) u_mod_b (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (red_start),
    .in_val     (red_b_in),
    .out_vld    (red_b_vld),
    .out_bucket (red_b_bkt)
  );

  // counter table
  wcc_pair_table #(.BUCKETS(BUCKETS), .COUNT_BITS(COUNT_BITS)) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .bump_vld (ring_q_vld_r),
    .bump_row (ring_q_r),
    .bump_col (col_bkt_r),
    .rd_req   (tbl_rd_req),
    .rd_row   (red_a_bkt),
    .rd_col   (red_b_bkt),
    .rd_count (tbl_count),
    .stat     (tbl_stat)
  );

  assign ptr_adv = (ptr_r == PW'(WINDOW - 1)) ? '0 : ptr_r + PW'(1);
  assign cnt_ext = EXT_W'(tbl_count);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    is_read_nxt   = is_read_r;
    ptr_nxt       = ptr_r;
    fill_nxt      = fill_r;
    col_bkt_nxt   = col_bkt_r;
    bump_idx_nxt  = bump_idx_r;
    ring_wr_en    = 1'b0;
    ring_rd_en    = 1'b0;
    tbl_rd_req    = 1'b0;
    out_valid_nxt = out_valid_r & out_stall;
    out_count_nxt = out_count_r;
    out_sat_nxt   = out_sat_r;
    case (state_r)
      ST_CLEAR: begin
        if (!tbl_stat.clearing) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (in_kind)
            KIND_CHAR: begin
              is_read_nxt = 1'b0;
              state_nxt   = ST_REDUCE;
            end
            KIND_START: begin
              fill_nxt = '0;
            end
            KIND_READ: begin
              is_read_nxt = 1'b1;
              state_nxt   = ST_REDUCE;
            end
            default: ;
          endcase
        end
      end
      ST_REDUCE: begin
        if (red_done) begin
          if (is_read_r) begin
            tbl_rd_req = 1'b1;
            state_nxt  = ST_RESULT;
          end else begin
            // push the bucket; count only once the ring is full
            ptr_nxt     = ptr_adv;
            ring_wr_en  = 1'b1;
            col_bkt_nxt = red_a_bkt;
            if (fill_r < FW'(WINDOW)) begin
              fill_nxt  = fill_r + FW'(1);
              state_nxt = ST_IDLE;
            end else begin
              bump_idx_nxt = '0;
              state_nxt    = ST_BUMP;
            end
          end
        end
      end
      ST_BUMP: begin
        // one ring entry a cycle into the table update pipe
        ring_rd_en   = 1'b1;
        bump_idx_nxt = bump_idx_r + PW'(1);
        if (bump_idx_r == PW'(WINDOW - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!ring_q_vld_r && !tbl_stat.busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = cnt_ext[OUT_COUNT_W-1:0];
          out_sat_nxt   = (tbl_count == CNT_MAX);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      is_read_r    <= 1'b0;
      ptr_r        <= '0;
      fill_r       <= '0;
      bump_idx_r   <= '0;
      ring_q_vld_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      is_read_r    <= is_read_nxt;
      ptr_r        <= ptr_nxt;
      fill_r       <= fill_nxt;
      bump_idx_r   <= bump_idx_nxt;
      ring_q_vld_r <= ring_rd_en;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_bkt_r   <= col_bkt_nxt;
    out_count_r <= out_count_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  // ring of recent buckets
  always_ff @(posedge clk) begin
    if (ring_wr_en) begin
      ring_mem[ptr_adv] <= red_a_bkt;
    end
    if (ring_rd_en) begin
      ring_q_r <= ring_mem[bump_idx_r];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_count     = out_count_r;
  assign out_saturated = out_sat_r;

endmodule

// File: rtl/window_cooccurrence_counter_chk.sv
// Port-level checker of the window co-occurrence counter, bound to the top level.
`include "window_cooccurrence_counter_macros.svh"

module window_cooccurrence_counter_chk import wcc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic [KIND_W-1:0]      in_kind,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [OUT_COUNT_W-1:0] out_count,
  input logic                   out_saturated
);

  // low 32 bits of a counter at its maximum
  localparam logic [OUT_COUNT_W-1:0] SAT_VAL = (COUNT_BITS >= OUT_COUNT_W) ?
    {OUT_COUNT_W{1'b1}} : OUT_COUNT_W'((64'd1 << COUNT_BITS) - 64'd1);

  // a held result does not change
  `WCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_count) && $stable(out_saturated))

  // characters and reads keep the block busy the next cycle
  `WCC_ASSERT_NEXT(a_work_stalls, in_valid && !in_stall && (in_kind == KIND_CHAR || in_kind == KIND_READ), in_stall)

  // a start of text leaves the block free to take an item the next cycle
  `WCC_ASSERT_NEXT(a_start_quick, in_valid && !in_stall && in_kind == KIND_START, !in_stall)

  // saturation flag matches the counter value
  `WCC_ASSERT_SAME(a_sat_value, out_valid && out_saturated, out_count == SAT_VAL)

endmodule

bind window_cooccurrence_counter window_cooccurrence_counter_chk #(
  .COUNT_BITS(COUNT_BITS)
) u_chk (.*);

// File: dv/window_cooccurrence_counter_test.sv
// Testbench for window_cooccurrence_counter: predicted pair counts checked against reads.
`timescale 1ns / 1ps

module window_cooccurrence_counter_test;
  import wcc_pkg::*;

  localparam int WINDOW     = WINDOW_DEF;
  localparam int BUCKETS    = BUCKETS_DEF;
  localparam int COUNT_BITS = COUNT_BITS_DEF;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  // longest quiet stretch is the table sweep after reset
  localparam int IDLE_LIMIT = 800000;

  typedef struct {
    logic [OUT_COUNT_W-1:0] count;
    logic                   saturated;
  } pair_read_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [KIND_W-1:0]      in_kind;
  logic [CHAR_W-1:0]      in_char_code;
  logic [IDX_W-1:0]       in_row;
  logic [IDX_W-1:0]       in_col;
  logic                   out_valid;
  logic                   out_stall;
  logic [OUT_COUNT_W-1:0] out_count;
  logic                   out_saturated;

  // predictor state
  logic [CHAR_W-1:0] ring_codes [WINDOW];
  int unsigned       ring_pos;
  int unsigned       chars_filled;
  longint unsigned   pair_tbl [int unsigned];
  pair_read_t        pending_reads [$];

  int          errors;
  int          items_sent;
  int          burst_left;
  bit          sender_gaps_on;
  bit          rx_quiet;
  int          rx_hold_req;
  int unsigned text_buckets [6];

  window_cooccurrence_counter #(
    .WINDOW    (WINDOW),
    .BUCKETS   (BUCKETS),
    .COUNT_BITS(COUNT_BITS)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_char_code (in_char_code),
    .in_row       (in_row),
    .in_col       (in_col),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_count    (out_count),
    .out_saturated(out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------
  function automatic void clear_counts();
    foreach (ring_codes[i]) ring_codes[i] = '0;
    ring_pos     = 0;
    chars_filled = 0;
    pair_tbl.delete();
  endfunction

  // push one code; once the ring is full, count every ring entry against it
  function automatic void count_char(logic [CHAR_W-1:0] code);
    int unsigned col_b;
    int unsigned slot;
    int unsigned key;
    ring_pos = (ring_pos + 1) % WINDOW;
    ring_codes[ring_pos] = code;
    if (chars_filled < WINDOW) begin
      chars_filled++;
      return;
    end
    col_b = code % BUCKETS;
    for (int j = 0; j < WINDOW; j++) begin
      slot = (ring_pos + j + 1) % WINDOW;
      key  = (ring_codes[slot] % BUCKETS) * BUCKETS + col_b;
      if (!pair_tbl.exists(key)) pair_tbl[key] = 0;
      if (pair_tbl[key] < COUNT_MAX) pair_tbl[key]++;
    end
  endfunction

  function automatic pair_read_t lookup_pair(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
    pair_read_t      r;
    int unsigned     key;
    longint unsigned v;
    key = (row % BUCKETS) * BUCKETS + (col % BUCKETS);
    v   = pair_tbl.exists(key) ? pair_tbl[key] : 64'd0;
    r.count     = v[OUT_COUNT_W-1:0];
    r.saturated = (v == COUNT_MAX);
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Input side: one transfer per call, bursts with random gaps
  // ---------------------------------------------------------------
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] code,
                           input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (sender_gaps_on && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 12);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid     = 1'b1;
    in_kind      = kind;
    in_char_code = code;
    in_row       = row;
    in_col       = col;
    do @(posedge clk); while (in_stall);
    items_sent++;
    case (kind)
      KIND_CHAR:  count_char(code);
      KIND_START: chars_filled = 0;
      KIND_READ:  pending_reads.insert(pending_reads.size(), lookup_pair(row, col));
      default: ;
    endcase
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] code);
    send_item(KIND_CHAR, code, IDX_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic send_read(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
    send_item(KIND_READ, CHAR_W'($urandom), row, col);
  endtask

  // sender goes quiet until every read has returned
  task automatic wait_reads_done();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------
  // Output side: stall pattern in segments, plus a long hold on request
  // ---------------------------------------------------------------
  initial begin : rx_pattern
    int hold_left;
    int seg_left;
    int stall_pct;
    hold_left = 0;
    seg_left  = 0;
    stall_pct = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (rx_quiet) begin
        out_stall = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(20, 200);
          case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 25;
            3:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        seg_left--;
        out_stall = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // compare each returned count with the oldest pending read
  always @(posedge clk) begin
    pair_read_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reads.size() == 0) begin
        $error("result with no read pending: count=%0d saturated=%0b",
               out_count, out_saturated);
        errors++;
      end else begin
        want = pending_reads.pop_front();
        if (out_count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_count);
          errors++;
        end
        if (out_saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, out_saturated);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin : watchdog
    int quiet;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("[window_cooccurrence_counter] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------
  function automatic logic [CHAR_W-1:0] text_code();
    if ($urandom_range(0, 9) == 0) return CHAR_W'($urandom);
    return {7'($urandom), IDX_W'(text_buckets[$urandom_range(0, 5)])};
  endfunction

  function automatic logic [IDX_W-1:0] text_index();
    if ($urandom_range(0, 3) == 0) return IDX_W'($urandom);
    return IDX_W'(text_buckets[$urandom_range(0, 5)]);
  endfunction

  // extremes, ignored kind, ring fill, counting, restart of text
  task automatic test_directed();
    send_read('0, '0);
    send_read('1, '1);
    send_item(KIND_UNUSED, '1, '1, '1);
    send_item(KIND_START, '0, '0, '0);
    // fill the ring: bucket 511 mostly, one bucket 0
    send_char(16'h0200);
    for (int i = 0; i < WINDOW - 1; i++) send_char(16'hFFFF);
    send_read('1, '1);
    // first counting chars; ring wraps here
    send_char(16'h01FF);
    send_char(16'h0000);
    send_read('1, '1);
    send_read('0, '1);
    send_read('1, '0);
    // restart mid text: ring kept, nothing counted while refilling
    send_item(KIND_START, '1, '1, '1);
    send_char(16'hFE00);
    send_item(KIND_UNUSED, '0, '0, '0);
    send_read('1, '1);
    send_read('0, '0);
  endtask

  // well-formed texts with random content, some cut short, reads and noise mixed in
  task automatic test_random_texts(input int n_items);
    int text_len;
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      foreach (text_buckets[i]) begin
        case ($urandom_range(0, 9))
          0:       text_buckets[i] = 0;
          1:       text_buckets[i] = BUCKETS - 1;
          default: text_buckets[i] = $urandom_range(0, BUCKETS - 1);
        endcase
      end
      if ($urandom_range(0, 9) != 0) send_item(KIND_START, CHAR_W'($urandom), '0, '0);
      text_len = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 12) : $urandom_range(31, 90);
      for (int i = 0; i < text_len; i++) begin
        send_char(text_code());
        if ($urandom_range(0, 6) == 0) send_read(text_index(), text_index());
        if ($urandom_range(0, 40) == 0)
          send_item(KIND_UNUSED, CHAR_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
      end
    end
  endtask

  // receiver holds off long while reads keep coming, then sender drains
  task automatic test_result_backpressure();
    sender_gaps_on = 1'b0;
    rx_hold_req    = 400;
    for (int i = 0; i < 40; i++) begin
      if (i % 4 == 0) send_read(text_index(), text_index());
      else send_char(text_code());
    end
    sender_gaps_on = 1'b1;
    wait_reads_done();
  endtask

  // back-to-back transfers with the receiver never stalling
  task automatic test_full_rate();
    sender_gaps_on = 1'b0;
    rx_quiet       = 1'b1;
    burst_left     = 0;
    send_item(KIND_START, '0, '0, '0);
    for (int i = 0; i < 150; i++) begin
      if (i % 3 == 2) send_read(text_index(), text_index());
      else send_char(text_code());
    end
    wait_reads_done();
    rx_quiet       = 1'b0;
    sender_gaps_on = 1'b1;
  endtask

  initial begin
    errors         = 0;
    items_sent     = 0;
    burst_left     = 0;
    sender_gaps_on = 1'b1;
    rx_quiet       = 1'b0;
    rx_hold_req    = 0;
    foreach (text_buckets[i]) text_buckets[i] = i;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_kind      = KIND_CHAR;
    in_char_code = '0;
    in_row       = '0;
    in_col       = '0;
    clear_counts();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_texts(1150);
    test_result_backpressure();
    test_full_rate();
    test_random_texts(60);

    wait_reads_done();
    repeat (64) @(posedge clk);
    if (errors == 0) begin
      $display("[window_cooccurrence_counter] OK");
    end else begin
      $display("[window_cooccurrence_counter] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/wcc_pkg.sv
rtl/wcc_bucket_mod.sv
rtl/wcc_pair_table.sv
rtl/window_cooccurrence_counter.sv
rtl/window_cooccurrence_counter_chk.sv
dv/window_cooccurrence_counter_test.sv
